// ----- src/bpv_pkg.sv -----
// shared types and constants of the bsp point location and visibility block
`timescale 1ns / 1ps
package bpv_pkg;

    // field widths
    localparam int COORD_W     = 24;
    localparam int NORM_W      = 16;
    localparam int CHILD_W     = 13;
    localparam int REF_W       = 12;
    localparam int CONT_W      = 32;
    localparam int DIFF_W      = 25;
    localparam int SQ_W        = 52;
    localparam int ROOT_W      = 26;
    localparam int FRAC_SHIFT  = 8;
    localparam int STEP_W      = ROOT_W - FRAC_SHIFT;
    localparam int DIST_SHIFT  = 14;
    localparam int PROD_W      = 40;
    localparam int DOT_W       = 43;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam int MOD_W       = 18;
    localparam int BIT_W       = 5;
    localparam int PLANE_WORD  = 3 * NORM_W + COORD_W;
    localparam int IN_DATA_W   = 232;
    localparam int OUT_DATA_W  = 48;

    // command codes on the input tuser
    localparam logic [2:0] CMD_LOAD_NODE  = 3'd0;
    localparam logic [2:0] CMD_LOAD_PLANE = 3'd1;
    localparam logic [2:0] CMD_LOAD_LEAF  = 3'd2;
    localparam logic [2:0] CMD_LOCATE     = 3'd3;
    localparam logic [2:0] CMD_VISIBILITY = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEPTH = 2'd1;
    localparam logic [1:0] ST_STEPS = 2'd2;

    // register index bit of paddr
    localparam logic REG_SOLID_MASK = 1'b0;

    typedef enum logic [2:0] {
        K_LOAD_NODE,
        K_LOAD_PLANE,
        K_LOAD_LEAF,
        K_LOCATE,
        K_VISIBLE,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind                        kind;
        logic [REF_W-1:0]             index;
        logic [REF_W-1:0]             plane_number;
        logic [CHILD_W-1:0]           child_front;
        logic [CHILD_W-1:0]           child_back;
        logic [CONT_W-1:0]            leaf_contents;
        logic [2:0][COORD_W-1:0]      start_pt;
        logic [2:0][COORD_W-1:0]      end_pt;
    } t_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              visible;
        logic [REF_W-1:0]  leaf_index;
        logic [CONT_W-1:0] found_contents;
    } t_result;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOAD_MUL,
        BK_LOAD_WR,
        BK_NODE_RD,
        BK_NODE_WAIT,
        BK_PLANE_WAIT,
        BK_SUM,
        BK_LEAF_WAIT,
        BK_SQ,
        BK_SQRT,
        BK_RANGE,
        BK_DIV,
        BK_STEP,
        BK_POINT,
        BK_OUT
    } t_bk_state;

endpackage

// ----- src/bpv_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module bpv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/bpv_front.sv -----
// front end: item intake, command classification and two-entry queue
`timescale 1ns / 1ps
module bpv_front #(
    parameter int NODE_COUNT  = 4096,
    parameter int PLANE_COUNT = 4096,
    parameter int LEAF_COUNT  = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bpv_pkg::IN_DATA_W-1:0]   i_tdata,
    input  logic [2:0]                      i_tuser,
    output logic                            o_q_valid,
    output bpv_pkg::t_item                  o_q_item,
    input  logic                            i_q_pop
);
    import bpv_pkg::*;

    t_item      n_item;
    t_item      r_slot [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    logic       push;
    logic       pop;

    // classify: out-of-range loads and unknown codes become no-ops
    always_comb begin
        n_item.index         = i_tdata[11:0];
        n_item.plane_number  = i_tdata[23:12];
        n_item.child_front   = i_tdata[36:24];
        n_item.child_back    = i_tdata[49:37];
        n_item.leaf_contents = i_tdata[81:50];
        n_item.start_pt[0]   = i_tdata[105:82];
        n_item.start_pt[1]   = i_tdata[129:106];
        n_item.start_pt[2]   = i_tdata[153:130];
        n_item.end_pt[0]     = i_tdata[177:154];
        n_item.end_pt[1]     = i_tdata[201:178];
        n_item.end_pt[2]     = i_tdata[225:202];
        unique case (i_tuser)
            CMD_LOAD_NODE: begin
                n_item.kind = (32'(i_tdata[11:0]) < NODE_COUNT) ? K_LOAD_NODE : K_NOP;
            end
            CMD_LOAD_PLANE: begin
                n_item.kind = (32'(i_tdata[11:0]) < PLANE_COUNT) ? K_LOAD_PLANE : K_NOP;
            end
            CMD_LOAD_LEAF: begin
                n_item.kind = (32'(i_tdata[11:0]) < LEAF_COUNT) ? K_LOAD_LEAF : K_NOP;
            end
            CMD_LOCATE:     n_item.kind = K_LOCATE;
            CMD_VISIBILITY: n_item.kind = K_VISIBLE;
            default:        n_item.kind = K_NOP;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end
endmodule

// ----- src/bpv_back.sv -----
// back end: table loads, tree walk, segment stepping and result register
`timescale 1ns / 1ps
module bpv_back #(
    parameter int NODE_COUNT  = 4096,
    parameter int PLANE_COUNT = 4096,
    parameter int LEAF_COUNT  = 4096,
    parameter int MAX_DEPTH   = 64,
    parameter int MAX_STEPS   = 65535
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  bpv_pkg::t_item                i_q_item,
    output logic                          o_q_pop,
    input  logic [bpv_pkg::CONT_W-1:0]    i_solid_mask,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bpv_pkg::t_result              o_result
);
    import bpv_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int PW = $clog2(PLANE_COUNT);
    localparam int LW = $clog2(LEAF_COUNT);
    localparam int CW = (NW > LW) ? NW : LW;
    localparam int VW = $clog2(MAX_DEPTH);
    localparam int NODE_WORD = PW + 2 * (CW + 1);
    localparam logic [RECIP_W-1:0] RCP_NODE  = RECIP_W'((1 << RECIP_SHIFT) / NODE_COUNT);
    localparam logic [RECIP_W-1:0] RCP_PLANE = RECIP_W'((1 << RECIP_SHIFT) / PLANE_COUNT);
    localparam logic [RECIP_W-1:0] RCP_LEAF  = RECIP_W'((1 << RECIP_SHIFT) / LEAF_COUNT);

    // remainder from a floor-reciprocal quotient, which is low by at most one
    function automatic logic [MOD_W-1:0] wrap_ref(input logic [REF_W-1:0] v,
                                                  input logic [REF_W-1:0] q,
                                                  input logic [MOD_W-1:0] n);
        logic [MOD_W-1:0] qn;
        logic [MOD_W-1:0] r;
        qn = MOD_W'(q) * n;
        r  = MOD_W'(v) - qn;
        if (r >= n) begin
            r = r - n;
        end
        return r;
    endfunction

    function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W-1:0] d);
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    t_bk_state n_state;
    t_bk_state r_state;

    t_item   r_item;
    t_result r_pend;
    t_result r_res;
    logic    r_out_valid;

    // load path
    logic [REF_W-1:0]   mod_v   [3];
    logic [MOD_W-1:0]   mod_n   [3];
    logic [RECIP_W-1:0] mod_rcp [3];
    logic [35:0]        mod_p   [3];
    logic [REF_W-1:0]   r_mq    [3];
    logic [MOD_W-1:0]   wr      [3];
    logic               cf_neg;
    logic               cb_neg;

    // walk
    logic [NW-1:0]              r_node;
    logic [VW-1:0]              r_visits;
    logic signed [COORD_W-1:0]  r_pt [3];
    logic                       r_cf_leaf;
    logic                       r_cb_leaf;
    logic [CW-1:0]              r_cf_idx;
    logic [CW-1:0]              r_cb_idx;
    logic signed [PROD_W-1:0]   r_prod [3];
    logic signed [COORD_W-1:0]  r_dist;
    logic [LW-1:0]              r_leaf;
    logic signed [DOT_W-1:0]    dot;
    logic                       dot_pos;
    logic                       sel_leaf;
    logic [CW-1:0]              sel_idx;
    logic                       at_depth;

    // segment
    logic signed [COORD_W-1:0]  r_e [3];
    logic signed [DIFF_W-1:0]   r_d [3];
    logic [1:0]                 r_ax;
    logic [SQ_W-1:0]            r_sq;
    logic [ROOT_W-1:0]          r_root;
    logic [ROOT_W:0]            r_rem;
    logic [BIT_W-1:0]           r_bit;
    logic [STEP_W-1:0]          r_steps;
    logic [DIFF_W-1:0]          r_dq;
    logic [STEP_W-1:0]          r_drem;
    logic [DIFF_W-1:0]          r_a [3];
    logic [STEP_W-1:0]          r_b [3];
    logic [DIFF_W-1:0]          r_acc_q [3];
    logic [STEP_W-1:0]          r_acc_r [3];
    logic [STEP_W-1:0]          r_k;
    logic signed [2*DIFF_W-1:0] sq_p;
    logic [ROOT_W+2:0]          rt_rem2;
    logic [ROOT_W+2:0]          rt_trial;
    logic                       rt_ge;
    logic [STEP_W:0]            dv_sh;
    logic                       dv_ge;
    logic [STEP_W-1:0]          dv_rem;
    logic [DIFF_W-1:0]          dv_quo;
    logic [STEP_W-1:0]          steps_now;
    logic                       sqrt_last;
    logic                       div_last;
    logic                       leaf_block;
    logic                       out_free;

    // memories
    logic                  node_we;
    logic [NW-1:0]         node_addr;
    logic [NODE_WORD-1:0]  node_wdata;
    logic [NODE_WORD-1:0]  node_q;
    logic                  plane_we;
    logic [PW-1:0]         plane_addr;
    logic [PLANE_WORD-1:0] plane_wdata;
    logic [PLANE_WORD-1:0] plane_q;
    logic                  leaf_we;
    logic [LW-1:0]         leaf_addr;
    logic [CONT_W-1:0]     leaf_q;

    // ---------------- load wrapping ----------------
    assign cf_neg = r_item.child_front[CHILD_W-1];
    assign cb_neg = r_item.child_back[CHILD_W-1];

    always_comb begin
        mod_v[0]   = r_item.plane_number;
        mod_n[0]   = MOD_W'(PLANE_COUNT);
        mod_rcp[0] = RCP_PLANE;
        mod_v[1]   = cf_neg ? ~r_item.child_front[REF_W-1:0] : r_item.child_front[REF_W-1:0];
        mod_n[1]   = cf_neg ? MOD_W'(LEAF_COUNT) : MOD_W'(NODE_COUNT);
        mod_rcp[1] = cf_neg ? RCP_LEAF : RCP_NODE;
        mod_v[2]   = cb_neg ? ~r_item.child_back[REF_W-1:0] : r_item.child_back[REF_W-1:0];
        mod_n[2]   = cb_neg ? MOD_W'(LEAF_COUNT) : MOD_W'(NODE_COUNT);
        mod_rcp[2] = cb_neg ? RCP_LEAF : RCP_NODE;
        for (int i = 0; i < 3; i++) begin
            mod_p[i] = 36'(mod_v[i]) * 36'(mod_rcp[i]);
            wr[i]    = wrap_ref(mod_v[i], r_mq[i], mod_n[i]);
        end
    end

    // ---------------- walk arithmetic ----------------
    assign dot = DOT_W'(r_prod[0]) + DOT_W'(r_prod[1]) + DOT_W'(r_prod[2])
               - (DOT_W'(r_dist) <<< DIST_SHIFT);
    assign dot_pos  = !dot[DOT_W-1] && (dot != '0);
    assign sel_leaf = dot_pos ? r_cf_leaf : r_cb_leaf;
    assign sel_idx  = dot_pos ? r_cf_idx : r_cb_idx;
    assign at_depth = (r_visits == VW'(MAX_DEPTH - 1));
    assign leaf_block = |(leaf_q & i_solid_mask);

    // ---------------- segment arithmetic ----------------
    assign sq_p      = (2*DIFF_W)'(r_d[r_ax]) * (2*DIFF_W)'(r_d[r_ax]);
    assign rt_rem2   = {r_rem, r_sq[SQ_W-1 -: 2]};
    assign rt_trial  = (ROOT_W+3)'({r_root, 2'b01});
    assign rt_ge     = (rt_rem2 >= rt_trial);
    assign dv_sh     = {r_drem, r_dq[DIFF_W-1]};
    assign dv_ge     = (dv_sh >= (STEP_W+1)'(r_steps));
    assign dv_rem    = dv_ge ? STEP_W'(dv_sh - (STEP_W+1)'(r_steps)) : dv_sh[STEP_W-1:0];
    assign dv_quo    = {r_dq[DIFF_W-2:0], dv_ge};
    assign steps_now = r_root[ROOT_W-1:FRAC_SHIFT];
    assign sqrt_last = (r_bit == BIT_W'(ROOT_W - 1));
    assign div_last  = (r_bit == BIT_W'(DIFF_W - 1));
    assign out_free  = !r_out_valid || i_ready;

    // ---------------- memory ports ----------------
    assign node_we    = (r_state == BK_LOAD_WR) && (r_item.kind == K_LOAD_NODE);
    assign node_addr  = node_we ? NW'(r_item.index) : r_node;
    assign node_wdata = {PW'(wr[0]), cf_neg, CW'(wr[1]), cb_neg, CW'(wr[2])};

    assign plane_we    = (r_state == BK_LOAD_WR) && (r_item.kind == K_LOAD_PLANE);
    assign plane_addr  = plane_we ? PW'(r_item.index) : node_q[NODE_WORD-1 -: PW];
    assign plane_wdata = {r_item.end_pt[0], r_item.start_pt[2][NORM_W-1:0],
                          r_item.start_pt[1][NORM_W-1:0], r_item.start_pt[0][NORM_W-1:0]};

    assign leaf_we   = (r_state == BK_LOAD_WR) && (r_item.kind == K_LOAD_LEAF);
    assign leaf_addr = leaf_we ? LW'(r_item.index) : LW'(sel_idx);

    bpv_ram #(.WIDTH(NODE_WORD), .DEPTH(NODE_COUNT)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_addr  (node_addr),
        .i_wdata (node_wdata),
        .o_rdata (node_q)
    );

    bpv_ram #(.WIDTH(PLANE_WORD), .DEPTH(PLANE_COUNT)) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (plane_we),
        .i_addr  (plane_addr),
        .i_wdata (plane_wdata),
        .o_rdata (plane_q)
    );

    bpv_ram #(.WIDTH(CONT_W), .DEPTH(LEAF_COUNT)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_addr  (leaf_addr),
        .i_wdata (r_item.leaf_contents),
        .o_rdata (leaf_q)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.kind)
                        K_LOAD_NODE, K_LOAD_PLANE, K_LOAD_LEAF: n_state = BK_LOAD_MUL;
                        K_LOCATE:  n_state = BK_NODE_RD;
                        K_VISIBLE: n_state = BK_SQ;
                        default:   n_state = BK_OUT;
                    endcase
                end
            end
            BK_LOAD_MUL:   n_state = BK_LOAD_WR;
            BK_LOAD_WR:    n_state = BK_OUT;
            BK_NODE_RD:    n_state = BK_NODE_WAIT;
            BK_NODE_WAIT:  n_state = BK_PLANE_WAIT;
            BK_PLANE_WAIT: n_state = BK_SUM;
            BK_SUM: begin
                if (sel_leaf) begin
                    n_state = BK_LEAF_WAIT;
                end else if (at_depth) begin
                    n_state = BK_OUT;
                end else begin
                    n_state = BK_NODE_RD;
                end
            end
            BK_LEAF_WAIT: begin
                if (r_item.kind == K_LOCATE || leaf_block || r_k == r_steps) begin
                    n_state = BK_OUT;
                end else begin
                    n_state = BK_STEP;
                end
            end
            BK_SQ:    n_state = (r_ax == 2'd2) ? BK_SQRT : BK_SQ;
            BK_SQRT:  n_state = sqrt_last ? BK_RANGE : BK_SQRT;
            BK_RANGE: begin
                if (32'(steps_now) > MAX_STEPS || steps_now == '0) begin
                    n_state = BK_OUT;
                end else begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV:   n_state = (div_last && r_ax == 2'd2) ? BK_STEP : BK_DIV;
            BK_STEP:  n_state = BK_POINT;
            BK_POINT: n_state = BK_NODE_RD;
            BK_OUT:   n_state = out_free ? BK_IDLE : BK_OUT;
            default:  n_state = BK_IDLE;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_item   <= i_q_item;
                r_pend   <= '0;
                r_node   <= '0;
                r_visits <= '0;
                r_sq     <= '0;
                r_ax     <= 2'd0;
                r_k      <= '0;
                r_steps  <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_pt[i] <= $signed(i_q_item.start_pt[i]);
                    r_e[i]  <= $signed(i_q_item.end_pt[i]);
                    r_d[i]  <= DIFF_W'($signed(i_q_item.end_pt[i]))
                             - DIFF_W'($signed(i_q_item.start_pt[i]));
                end
            end
            BK_LOAD_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    r_mq[i] <= mod_p[i][RECIP_SHIFT +: REF_W];
                end
            end
            BK_NODE_WAIT: begin
                r_cf_leaf <= node_q[2*CW+1];
                r_cf_idx  <= node_q[CW+1 +: CW];
                r_cb_leaf <= node_q[CW];
                r_cb_idx  <= node_q[CW-1:0];
            end
            BK_PLANE_WAIT: begin
                r_prod[0] <= PROD_W'(r_pt[0]) * PROD_W'($signed(plane_q[NORM_W-1:0]));
                r_prod[1] <= PROD_W'(r_pt[1]) * PROD_W'($signed(plane_q[2*NORM_W-1:NORM_W]));
                r_prod[2] <= PROD_W'(r_pt[2]) * PROD_W'($signed(plane_q[3*NORM_W-1:2*NORM_W]));
                r_dist    <= $signed(plane_q[PLANE_WORD-1 -: COORD_W]);
            end
            BK_SUM: begin
                r_leaf   <= LW'(sel_idx);
                r_node   <= NW'(sel_idx);
                r_visits <= r_visits + VW'(1);
                if (!sel_leaf && at_depth) begin
                    r_pend.status <= ST_DEPTH;
                end
            end
            BK_LEAF_WAIT: begin
                if (r_item.kind == K_LOCATE) begin
                    r_pend.leaf_index     <= REF_W'(r_leaf);
                    r_pend.found_contents <= leaf_q;
                end else if (!leaf_block && r_k == r_steps) begin
                    r_pend.visible <= 1'b1;
                end
            end
            BK_SQ: begin
                r_sq <= r_sq + SQ_W'(sq_p);
                r_ax <= r_ax + 2'd1;
                r_rem  <= '0;
                r_root <= '0;
                r_bit  <= '0;
            end
            BK_SQRT: begin
                r_rem  <= rt_ge ? (ROOT_W+1)'(rt_rem2 - rt_trial) : (ROOT_W+1)'(rt_rem2);
                r_root <= {r_root[ROOT_W-2:0], rt_ge};
                r_sq   <= r_sq << 2;
                r_bit  <= r_bit + BIT_W'(1);
            end
            BK_RANGE: begin
                r_steps <= steps_now;
                r_ax    <= 2'd0;
                r_bit   <= '0;
                r_dq    <= abs_d(r_d[0]);
                r_drem  <= '0;
                if (32'(steps_now) > MAX_STEPS) begin
                    r_pend.status <= ST_STEPS;
                end else if (steps_now == '0) begin
                    r_pend.visible <= 1'b1;
                end
            end
            BK_DIV: begin
                if (div_last) begin
                    r_a[r_ax]     <= dv_quo;
                    r_b[r_ax]     <= dv_rem;
                    r_acc_q[r_ax] <= '0;
                    r_acc_r[r_ax] <= '0;
                    r_ax          <= r_ax + 2'd1;
                    r_bit         <= '0;
                    r_drem        <= '0;
                    r_dq          <= abs_d(r_d[(r_ax == 2'd0) ? 1 : 2]);
                end else begin
                    r_dq   <= dv_quo;
                    r_drem <= dv_rem;
                    r_bit  <= r_bit + BIT_W'(1);
                end
            end
            BK_STEP: begin
                // running quotient and remainder of |d| * k / steps
                for (int i = 0; i < 3; i++) begin
                    if ((STEP_W+1)'(r_acc_r[i]) + (STEP_W+1)'(r_b[i])
                            >= (STEP_W+1)'(r_steps)) begin
                        r_acc_r[i] <= STEP_W'((STEP_W+1)'(r_acc_r[i]) + (STEP_W+1)'(r_b[i])
                                    - (STEP_W+1)'(r_steps));
                        r_acc_q[i] <= r_acc_q[i] + r_a[i] + DIFF_W'(1);
                    end else begin
                        r_acc_r[i] <= r_acc_r[i] + r_b[i];
                        r_acc_q[i] <= r_acc_q[i] + r_a[i];
                    end
                end
                r_k <= r_k + STEP_W'(1);
            end
            BK_POINT: begin
                for (int i = 0; i < 3; i++) begin
                    r_pt[i] <= r_d[i][DIFF_W-1]
                             ? COORD_W'(26'(r_e[i]) + 26'(r_acc_q[i]))
                             : COORD_W'(26'(r_e[i]) - 26'(r_acc_q[i]));
                end
                r_node   <= '0;
                r_visits <= '0;
            end
            default: begin
            end
        endcase
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == BK_OUT && out_free) begin
            r_res <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == BK_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_res;

    // ---------------- checks ----------------
    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_OUT && r_out_valid && !i_ready) |=> (r_state == BK_OUT))
        else $error("result dropped while output register was full");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != BK_IDLE))
        else $error("queue pop did not start work");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_STEP) |-> (r_k < r_steps))
        else $error("step counter passed step count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_POINT) |-> (r_acc_r[0] < r_steps && r_acc_r[1] < r_steps
                                   && r_acc_r[2] < r_steps))
        else $error("step remainder out of range");

    a_sqrt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SQ && r_ax == 2'd2) |=> (r_state == BK_SQRT && r_bit == '0))
        else $error("square root not started from zero");
endmodule

// ----- src/bsp_point_location_visibility.sv -----
// top level of the bsp point location and visibility block
`timescale 1ns / 1ps
//
//  channel   dir   handshake                      payload
//  s_axis    in    s_axis_tvalid/s_axis_tready    tuser command, tdata item fields
//  m_axis    out   m_axis_tvalid/m_axis_tready    tdata status, visible, leaf, contents
//  apb       in    psel/penable/pwrite/pready     solid_mask at byte address 0
//
//  a load passes through a reciprocal multiply and a table write; a locate walks the tree,
//  each node visit reading the node ram, then the plane ram, then summing the dot product
//  a visibility test takes the segment length, its square root and a division per axis,
//  then per step a new point and a tree walk to its leaf, ended early by a solid leaf
//  reset clears control only; the tables are undefined until loaded, with no clearing pass
//  a two-entry queue between intake and executor lets the input run ahead of a stalled output
//
module bsp_point_location_visibility #(
    parameter int NODE_COUNT  = 4096,
    parameter int PLANE_COUNT = 4096,
    parameter int LEAF_COUNT  = 4096,
    parameter int MAX_DEPTH   = 64,
    parameter int MAX_STEPS   = 65535
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // index, plane_number, child_front, child_back, leaf_contents,
    // start_x, start_y, start_z, end_x, end_y, end_z, zero fill
    input  logic [bpv_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [2:0]                      s_axis_tuser,
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status, visible, leaf_index, found_contents, zero fill
    output logic [bpv_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bpv_pkg::*;

    logic [31:0] r_solid_mask;
    logic        q_valid;
    logic        q_pop;
    t_item       q_item;
    t_result     result;

    // solid mask register, written in the apb access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SOLID_MASK) ? r_solid_mask : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solid_mask <= 32'd1;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_SOLID_MASK) begin
            r_solid_mask <= pwdata;
        end
    end

    // intake and classification
    bpv_front #(
        .NODE_COUNT  (NODE_COUNT),
        .PLANE_COUNT (PLANE_COUNT),
        .LEAF_COUNT  (LEAF_COUNT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .i_tuser   (s_axis_tuser),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // executor with its tables and result register
    bpv_back #(
        .NODE_COUNT  (NODE_COUNT),
        .PLANE_COUNT (PLANE_COUNT),
        .LEAF_COUNT  (LEAF_COUNT),
        .MAX_DEPTH   (MAX_DEPTH),
        .MAX_STEPS   (MAX_STEPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .i_solid_mask (r_solid_mask),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    // pack result fields from the lowest bit up
    assign m_axis_tdata = {1'b0, result.found_contents, result.leaf_index,
                           result.visible, result.status};
endmodule

// ----- tb/testbench.sv -----
// self-checking testbench of the bsp point location and visibility block
`timescale 1ns / 1ps
module testbench;
    import bpv_pkg::*;

    localparam int TBL          = 4096;
    localparam int WALK_LIMIT   = 64;
    localparam int STEP_LIMIT   = 65535;
    localparam int TREE_SPAN    = 16;     // entries the random tree lives in
    localparam int SEG_CAP      = 40;     // longest walkable segment, in steps
    localparam int STALL_LIMIT  = 60000;  // idle cycles before the watchdog fires
    localparam int PHASE_ITEMS  = 300;
    localparam logic [2:0] MASK_ADDR = {REG_SOLID_MASK, 2'b00};

    // one input item with its command
    typedef struct {
        logic [2:0]         cmd;
        logic [REF_W-1:0]   index;
        logic [REF_W-1:0]   plane_number;
        logic [CHILD_W-1:0] child_front;
        logic [CHILD_W-1:0] child_back;
        logic [CONT_W-1:0]  leaf_contents;
        logic [COORD_W-1:0] sp [3];
        logic [COORD_W-1:0] ep [3];
    } bsp_cmd_t;

    // queue of expected results, checked in order
    class result_board;
        t_result pending[$];
        int      errors;

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t  result %s: got %0h, expected %0h", $realtime, what, got, want);
        endtask

        function void note(t_result r);
            pending.push_back(r);
        endfunction

        task check(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("without pending item", got, 0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.visible !== want.visible) report("visible", got.visible, want.visible);
            if (got.leaf_index !== want.leaf_index)
                report("leaf_index", got.leaf_index, want.leaf_index);
            if (got.found_contents !== want.found_contents)
                report("found_contents", got.found_contents, want.found_contents);
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [2:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    bsp_point_location_visibility u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    result_board board = new();

    // shadow of the block's tables, with a written flag per entry
    logic [REF_W-1:0]   sh_plane_of  [TBL];
    logic [CHILD_W-1:0] sh_front     [TBL];
    logic [CHILD_W-1:0] sh_back      [TBL];
    logic [NORM_W-1:0]  sh_normal    [TBL][3];
    logic [COORD_W-1:0] sh_dist      [TBL];
    logic [CONT_W-1:0]  sh_contents  [TBL];
    bit                 node_known   [TBL];
    bit                 plane_known  [TBL];
    bit                 leaf_known   [TBL];
    logic [CONT_W-1:0]  sh_solid_mask;

    bit quiet;      // no idling on either side once set
    int accepted;

    always #5 i_clk = ~i_clk;

    // watchdog: cycles in which neither channel moves an item
    int stall_cycles;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: sample at the rising edge
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status         = m_axis_tdata[1:0];
            got.visible        = m_axis_tdata[2];
            got.leaf_index     = m_axis_tdata[14:3];
            got.found_contents = m_axis_tdata[46:15];
            board.check(got);
        end
    end

    // result side: ready stalls in random bursts
    int ready_hold;
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_axis_tready = 1'b0;
            ready_hold    = $urandom_range(1, 12) - 1;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // walks the shadow tree; ok is cleared if an unwritten entry would be read
    function automatic logic [1:0] walk_tree(longint px, longint py, longint pz,
                                             output int leaf, output bit ok);
        int     node;
        int     pl;
        longint dot;
        logic [CHILD_W-1:0] c;
        node = 0;
        leaf = 0;
        ok   = 1;
        for (int v = 0; v < WALK_LIMIT; v++) begin
            if (!node_known[node]) begin
                ok = 0;
                return ST_OK;
            end
            pl = sh_plane_of[node];
            if (!plane_known[pl]) begin
                ok = 0;
                return ST_OK;
            end
            dot = px * longint'($signed(sh_normal[pl][0]))
                + py * longint'($signed(sh_normal[pl][1]))
                + pz * longint'($signed(sh_normal[pl][2]))
                - longint'($signed(sh_dist[pl])) * (longint'(1) << DIST_SHIFT);
            c = (dot > 0) ? sh_front[node] : sh_back[node];
            if (c[CHILD_W-1]) begin
                leaf = -int'($signed(c)) - 1;
                if (!leaf_known[leaf]) ok = 0;
                return ST_OK;
            end
            node = c;
        end
        return ST_DEPTH;
    endfunction

    function automatic longint int_root(longint v);
        longint r;
        r = 0;
        for (int b = 30; b >= 0; b--)
            if ((r | (longint'(1) << b)) * (r | (longint'(1) << b)) <= v)
                r = r | (longint'(1) << b);
        return r;
    endfunction

    // expected result of one item; loads update the shadow tables.
    // a query that would reach an unwritten entry or step a segment past SEG_CAP gives ok = 0
    function automatic void predict_result(bsp_cmd_t it, output t_result r, output bit ok,
                                           input bit commit);
        longint s [3];
        longint e [3];
        longint d [3];
        longint sq;
        longint steps;
        int     leaf;
        logic [1:0] st;
        r  = '0;
        ok = 1;
        for (int i = 0; i < 3; i++) begin
            s[i] = $signed(it.sp[i]);
            e[i] = $signed(it.ep[i]);
        end
        case (it.cmd)
            CMD_LOAD_NODE: if (commit) begin
                sh_plane_of[it.index] = it.plane_number;
                sh_front[it.index]    = it.child_front;
                sh_back[it.index]     = it.child_back;
                node_known[it.index]  = 1;
            end
            CMD_LOAD_PLANE: if (commit) begin
                for (int i = 0; i < 3; i++) sh_normal[it.index][i] = it.sp[i][NORM_W-1:0];
                sh_dist[it.index]     = it.ep[0];
                plane_known[it.index] = 1;
            end
            CMD_LOAD_LEAF: if (commit) begin
                sh_contents[it.index] = it.leaf_contents;
                leaf_known[it.index]  = 1;
            end
            CMD_LOCATE: begin
                st = walk_tree(s[0], s[1], s[2], leaf, ok);
                r.status = st;
                if (st == ST_OK) begin
                    r.leaf_index     = leaf;
                    r.found_contents = sh_contents[leaf];
                end
            end
            CMD_VISIBILITY: begin
                sq = 0;
                for (int i = 0; i < 3; i++) begin
                    d[i] = e[i] - s[i];
                    sq   = sq + d[i] * d[i];
                end
                steps = int_root(sq) >> FRAC_SHIFT;
                if (steps > STEP_LIMIT) begin
                    r.status = ST_STEPS;
                end else if (steps > SEG_CAP) begin
                    ok = 0;
                end else begin
                    r.visible = 1;
                    for (longint k = 1; k <= steps; k++) begin
                        st = walk_tree(e[0] - (d[0] * k) / steps, e[1] - (d[1] * k) / steps,
                                       e[2] - (d[2] * k) / steps, leaf, ok);
                        if (!ok) break;
                        if (st != ST_OK) begin
                            r.status  = ST_DEPTH;
                            r.visible = 0;
                            break;
                        end
                        if ((sh_contents[leaf] & sh_solid_mask) != 0) begin
                            r.visible = 0;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // one item onto the input channel; called at a falling edge, returns at one
    task automatic send_item(bsp_cmd_t it);
        t_result want;
        bit      ok;
        int      gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = it.cmd;
        s_axis_tdata  = {6'd0, it.ep[2], it.ep[1], it.ep[0], it.sp[2], it.sp[1], it.sp[0],
                         it.leaf_contents, it.child_back, it.child_front, it.plane_number,
                         it.index};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_result(it, want, ok, 1);
        board.note(want);
        accepted++;
        @(negedge i_clk);
    endtask

    // sends a query only when the walk stays on written, short paths
    task automatic send_query(bsp_cmd_t it);
        t_result want;
        bit      ok;
        predict_result(it, want, ok, 0);
        if (ok) send_item(it);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_mask(logic [31:0] value);
        drain();
        repeat (20) @(negedge i_clk);   // let the block go quiet
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = MASK_ADDR;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sh_solid_mask = value;
    endtask

    function automatic bsp_cmd_t blank_item(logic [2:0] cmd);
        bsp_cmd_t it;
        it.cmd           = cmd;
        it.index         = $urandom;
        it.plane_number  = $urandom;
        it.child_front   = $urandom;
        it.child_back    = $urandom;
        it.leaf_contents = $urandom;
        for (int i = 0; i < 3; i++) begin
            it.sp[i] = $urandom;
            it.ep[i] = $urandom;
        end
        return it;
    endfunction

    function automatic logic [CHILD_W-1:0] tree_child();
        if ($urandom_range(0, 9) < 7) return -CHILD_W'($urandom_range(1, TREE_SPAN));
        return $urandom_range(0, TREE_SPAN - 1);
    endfunction

    function automatic bsp_cmd_t node_load(int idx);
        bsp_cmd_t it;
        it = blank_item(CMD_LOAD_NODE);
        it.index        = idx;
        it.plane_number = $urandom_range(0, TREE_SPAN - 1);
        it.child_front  = tree_child();
        it.child_back   = tree_child();
        return it;
    endfunction

    function automatic bsp_cmd_t plane_load(int idx);
        bsp_cmd_t it;
        it = blank_item(CMD_LOAD_PLANE);
        it.index = idx;
        // distance kept near the origin so both sides of a plane get hit
        it.ep[0] = $signed(COORD_W'($urandom_range(0, 8191))) - 4096;
        return it;
    endfunction

    // a point near the origin, or anywhere in range
    function automatic logic [COORD_W-1:0] coord(bit wide);
        if (wide) return $urandom;
        return COORD_W'($urandom_range(0, 8191)) - COORD_W'(4096);
    endfunction

    function automatic bsp_cmd_t random_item();
        bsp_cmd_t it;
        int       pick;
        bit       wide;
        pick = $urandom_range(0, 99);
        wide = ($urandom_range(0, 7) == 0);
        if (pick < 10)       return node_load($urandom_range(0, TREE_SPAN - 1));
        else if (pick < 18)  return plane_load($urandom_range(0, TREE_SPAN - 1));
        else if (pick < 26) begin
            it = blank_item(CMD_LOAD_LEAF);
            if ($urandom_range(0, 1)) it.index = $urandom_range(0, TREE_SPAN - 1);
            // sparse contents so that masks both pass and block
            if ($urandom_range(0, 1)) it.leaf_contents = 1 << $urandom_range(0, 31);
            return it;
        end else if (pick < 28) begin
            it = blank_item(CMD_LOAD_NODE);
            it.index = $urandom_range(TREE_SPAN, TBL - 1);
            return it;
        end else if (pick < 31) begin
            return blank_item(3'($urandom_range(5, 7)));
        end else if (pick < 60) begin
            it = blank_item(CMD_LOCATE);
            for (int i = 0; i < 3; i++) it.sp[i] = coord(wide);
            return it;
        end
        it = blank_item(CMD_VISIBILITY);
        for (int i = 0; i < 3; i++) begin
            it.sp[i] = coord(wide);
            it.ep[i] = it.sp[i] + COORD_W'($urandom_range(0, 6000)) - COORD_W'(3000);
        end
        if (pick > 96) begin
            // far apart on every axis: past the step limit
            for (int i = 0; i < 3; i++) begin
                it.sp[i] = -COORD_W'($urandom_range(5000000, 8388608));
                it.ep[i] = COORD_W'($urandom_range(5100000, 8388607));
                if ($urandom_range(0, 1)) begin
                    it.sp[i] = -it.sp[i] - 1;
                    it.ep[i] = -it.ep[i];
                end
            end
        end
        return it;
    endfunction

    initial begin
        bsp_cmd_t    it;
        logic [31:0] masks [5];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD_NODE;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = MASK_ADDR;
        pwdata        = '0;
        quiet         = 0;
        accepted      = 0;
        ready_hold    = 0;
        stall_cycles  = 0;
        sh_solid_mask = 32'd1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // a small tree covering all entries the random part refers to
        for (int i = 0; i < TREE_SPAN; i++) begin
            send_item(node_load(i));
            send_item(plane_load(i));
            it = blank_item(CMD_LOAD_LEAF);
            it.index = i;
            send_item(it);
        end

        // directed: field extremes on loads far from the tree
        it = blank_item(CMD_LOAD_NODE);
        it.index = TBL - 1;  it.plane_number = TBL - 1;
        it.child_front = 13'h0fff;  it.child_back = 13'h1000;
        send_item(it);
        it = blank_item(CMD_LOAD_PLANE);
        it.index = TBL - 1;
        it.sp[0] = 24'h7fffff;  it.sp[1] = 24'h800000;  it.sp[2] = 24'h008000;
        it.ep[0] = 24'h800000;
        send_item(it);
        it = blank_item(CMD_LOAD_LEAF);
        it.index = TBL - 1;  it.leaf_contents = '1;
        send_item(it);
        it = blank_item(CMD_LOAD_LEAF);
        it.index = 0;  it.leaf_contents = '0;
        send_item(it);
        // unknown commands
        for (int c = 5; c <= 7; c++) send_item(blank_item(3'(c)));
        // locate at the coordinate extremes
        it = blank_item(CMD_LOCATE);
        for (int i = 0; i < 3; i++) it.sp[i] = 24'h7fffff;
        send_query(it);
        for (int i = 0; i < 3; i++) it.sp[i] = 24'h800000;
        send_query(it);
        // zero-length and sub-unit segments are visible
        it = blank_item(CMD_VISIBILITY);
        for (int i = 0; i < 3; i++) it.ep[i] = it.sp[i];
        send_item(it);
        it.ep[0] = it.sp[0] + 24'd255;
        send_item(it);
        // corner to corner: over the step limit
        for (int i = 0; i < 3; i++) begin
            it.sp[i] = 24'h800000;
            it.ep[i] = 24'h7fffff;
        end
        send_item(it);
        // node 0 pointing at itself: depth limit on locate and visibility
        it = node_load(0);
        it.child_front = 0;  it.child_back = 0;
        send_item(it);
        it = blank_item(CMD_LOCATE);
        for (int i = 0; i < 3; i++) it.sp[i] = coord(0);
        send_item(it);
        it = blank_item(CMD_VISIBILITY);
        for (int i = 0; i < 3; i++) begin
            it.sp[i] = 0;
            it.ep[i] = 24'd600;
        end
        send_item(it);
        send_item(node_load(0));

        // random phases, each under its own solid mask, the extremes among them
        masks[0] = 32'h0;
        masks[1] = 32'hffffffff;
        masks[2] = $urandom;
        masks[3] = 32'h80000000;
        masks[4] = 32'h1;
        for (int ph = 0; ph < 5; ph++) begin
            write_mask(masks[ph]);
            quiet = (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = random_item();
                if (it.cmd == CMD_LOCATE || it.cmd == CMD_VISIBILITY) send_query(it);
                else send_item(it);
                // sender holds off until everything is back
                if (n == PHASE_ITEMS / 2 && ph == 1) drain();
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- bsp_point_location_visibility.f -----
src/bpv_pkg.sv
src/bpv_ram.sv
src/bpv_front.sv
src/bpv_back.sv
src/bsp_point_location_visibility.sv
tb/testbench.sv
